@@ src/sdpa_pkg.sv @@
// Shared types, codes and exp table functions for the attention block.
`default_nettype none
package sdpa_pkg;

  localparam int WEIGHT_W = 17;

  localparam logic REQ_LOAD  = 1'b0;
  localparam logic REQ_FETCH = 1'b1;

  localparam logic CFG_HEAD_WIDTH  = 1'b0;
  localparam logic CFG_SCORE_SCALE = 1'b1;

  localparam logic [1:0] STATUS_VALID    = 2'd0;
  localparam logic [1:0] STATUS_EMPTY    = 2'd1;
  localparam logic [1:0] STATUS_OVERFLOW = 2'd2;

  typedef struct packed {
    logic clear;
    logic shift;
  } cell_ctl_t;

  // exp(-t), t in Q.30 up to one, alternating series to the twelfth term
  function automatic logic [63:0] exp_series(input logic [63:0] t);
    logic [63:0] sum;
    logic [63:0] term;
    sum  = 64'd1 << 30;
    term = 64'd1 << 30;
    for (int k = 1; k <= 12; k++) begin
      term = ((term * t) >> 30) / 64'(k);
      if ((k & 1) == 1) begin
        sum = sum - term;
      end else begin
        sum = sum + term;
      end
    end
    return sum;
  endfunction

  // table entry in Q.16 from the exact Q.30 argument
  function automatic logic [WEIGHT_W-1:0] exp_from_x(input logic [63:0] x);
    logic [63:0] n;
    logic [63:0] v;
    logic [63:0] e1;
    n  = x >> 30;
    v  = exp_series(x & ((64'd1 << 30) - 64'd1));
    e1 = exp_series(64'd1 << 30);
    for (int m = 0; m < 16; m++) begin
      if (64'(m) < n) begin
        v = (v * e1 + (64'd1 << 29)) >> 30;
      end
    end
    return WEIGHT_W'((v + (64'd1 << 13)) >> 14);
  endfunction

endpackage
`default_nettype wire

@@ src/sdpa_cell.sv @@
// One accumulator cell of the rotating output-column chain.
`default_nettype none
module sdpa_cell #(
  parameter int W = 16
) (
  input  wire logic               clk,
  input  wire sdpa_pkg::cell_ctl_t ctl,
  input  wire logic               is_tail,
  input  wire logic [W-1:0]       tail_in,
  input  wire logic [W-1:0]       nb_in,
  output logic      [W-1:0]       acc
);

  logic [W-1:0] acc_r;
  logic [W-1:0] acc_nxt;

  always_comb begin
    acc_nxt = acc_r;
    if (ctl.clear) begin
      acc_nxt = '0;
    end else if (ctl.shift) begin
      acc_nxt = is_tail ? tail_in : nb_in;
    end
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
  end

  assign acc = acc_r;

endmodule
`default_nettype wire

@@ src/sdpa_div.sv @@
// Restoring divider, one quotient bit per cycle, rounded half away and saturated.
`default_nettype none
module sdpa_div #(
  parameter int NUM_W = 40,
  parameter int DEN_W = 24
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    start,
  input  wire logic signed [NUM_W-1:0] num,
  input  wire logic        [DEN_W-1:0] den,
  output logic                         busy,
  output logic                         done,
  output logic             [15:0]      quo
);

  localparam int CW = $clog2(NUM_W + 1);

  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic             neg_r, neg_nxt;
  logic [NUM_W-1:0] q_r, q_nxt;
  logic [DEN_W-1:0] rem_r, rem_nxt;

  logic [DEN_W:0]   rs;
  logic [NUM_W:0]   qx;
  logic [NUM_W:0]   nq;
  logic             rnd;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    neg_nxt  = neg_r;
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    rs       = {rem_r, q_r[NUM_W-1]};
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CW'(NUM_W);
      neg_nxt  = num[NUM_W-1];
      q_nxt    = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
      rem_nxt  = '0;
    end else if (busy_r) begin
      if (rs >= {1'b0, den}) begin
        rem_nxt = DEN_W'(rs - {1'b0, den});
        q_nxt   = {q_r[NUM_W-2:0], 1'b1};
      end else begin
        rem_nxt = rs[DEN_W-1:0];
        q_nxt   = {q_r[NUM_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - CW'(1);
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    cnt_r <= cnt_nxt;
    neg_r <= neg_nxt;
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
  end

  always_comb begin
    rnd = ({rem_r, 1'b0} >= {1'b0, den});
    qx  = {1'b0, q_r} + (NUM_W + 1)'(rnd);
    nq  = -qx;
    if (neg_r) begin
      quo = (qx > (NUM_W + 1)'(32768)) ? 16'h8000 : nq[15:0];
    end else begin
      quo = (qx > (NUM_W + 1)'(32767)) ? 16'h7FFF : qx[15:0];
    end
  end

  assign busy = busy_r;
  assign done = done_r;

endmodule
`default_nettype wire

@@ src/scaled_dot_product_attention.sv @@
// Single-head scaled dot-product attention with table softmax, top level.
//
// Loads and fetches are taken one per cycle while the block is idle and the
// output register is free. The last load starts a compute burst: a row
// count of up to MAX_SEQ_LEN rows, then for each of the seq query rows the
// dot products on their own multiply-accumulate unit, the table lookups,
// the weighted sums rotating through a chain of MAX_HEAD_DIM accumulator
// cells, and the division of each column in the bit-serial divider, which
// takes ACC_W-bit numerators (ACC_W is 41 at the default sizes). No item is
// taken during the burst. There is no clearing pass after reset.
`default_nettype none
module scaled_dot_product_attention #(
  parameter int MAX_SEQ_LEN     = 64,
  parameter int MAX_HEAD_DIM    = 64,
  parameter int EXP_TABLE_DEPTH = 256
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic [0:0]  cfg_index,
  input  wire logic [15:0] cfg_data,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [47:0] in_tdata,   // query_value, key_value, value_value
  input  wire logic [0:0]  in_tuser,   // req_type
  input  wire logic        in_tlast,   // last_load
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic      [15:0] out_tdata,  // out_value
  output logic      [1:0]  out_tuser,  // status
  output logic             out_tlast   // out_last
);

  localparam int STORE_DEPTH = MAX_SEQ_LEN * MAX_HEAD_DIM;
  localparam int ADDR_W = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
  localparam int LC_W   = $clog2(STORE_DEPTH + 1);
  localparam int SQ_W   = $clog2(MAX_SEQ_LEN + 1);
  localparam int SI_W   = (MAX_SEQ_LEN > 1) ? $clog2(MAX_SEQ_LEN) : 1;
  localparam int HD_W   = $clog2(MAX_HEAD_DIM + 1);
  localparam int DOT_W  = 32 + $clog2(MAX_HEAD_DIM + 1);
  localparam int SP_W   = DOT_W + 17;
  localparam int SC_W   = DOT_W + 3;
  localparam int WW     = sdpa_pkg::WEIGHT_W;
  localparam int WS_W   = WW + $clog2(MAX_SEQ_LEN + 1);
  localparam int PW_W   = WW + 17;
  localparam int ACC_W  = PW_W + $clog2(MAX_SEQ_LEN + 1);
  localparam int IDX_W  = $clog2(EXP_TABLE_DEPTH);
  localparam int IP_W   = 20 + $clog2(EXP_TABLE_DEPTH + 1);

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_SEQ  = 4'd1;
  localparam logic [3:0] ST_ROW  = 4'd2;
  localparam logic [3:0] ST_DRD  = 4'd3;
  localparam logic [3:0] ST_DMUL = 4'd4;
  localparam logic [3:0] ST_DACC = 4'd5;
  localparam logic [3:0] ST_SCL  = 4'd6;
  localparam logic [3:0] ST_SRND = 4'd7;
  localparam logic [3:0] ST_WRD  = 4'd8;
  localparam logic [3:0] ST_WIDX = 4'd9;
  localparam logic [3:0] ST_WTAB = 4'd10;
  localparam logic [3:0] ST_CRD  = 4'd11;
  localparam logic [3:0] ST_CMUL = 4'd12;
  localparam logic [3:0] ST_CACC = 4'd13;
  localparam logic [3:0] ST_DIVS = 4'd14;
  localparam logic [3:0] ST_DIVW = 4'd15;

  // exp table
  logic [WW-1:0] exp_tab [EXP_TABLE_DEPTH];
  for (genvar g = 0; g < EXP_TABLE_DEPTH; g++) begin : g_exp
    localparam logic [63:0] XG = (64'(g) << 34) / EXP_TABLE_DEPTH;
    assign exp_tab[g] = sdpa_pkg::exp_from_x(XG);
  end

  // configuration
  logic [6:0]  head_width_r;
  logic [15:0] scale_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_width_r <= 7'd64;
      scale_r      <= 16'd4096;
    end else if (cfg_we) begin
      unique case (cfg_index)
        sdpa_pkg::CFG_HEAD_WIDTH:  head_width_r <= cfg_data[6:0];
        sdpa_pkg::CFG_SCORE_SCALE: scale_r      <= cfg_data;
        default: ;
      endcase
    end
  end

  // stores
  logic signed [15:0] q_mem [STORE_DEPTH];
  logic signed [15:0] k_mem [STORE_DEPTH];
  logic signed [15:0] v_mem [STORE_DEPTH];
  logic        [15:0] res_mem [STORE_DEPTH];
  logic signed [SC_W-1:0] sc_mem [MAX_SEQ_LEN];
  logic        [WW-1:0]   w_mem [MAX_SEQ_LEN];

  logic signed [15:0]     q_rd_r, k_rd_r, v_rd_r;
  logic        [15:0]     res_rd_r;
  logic signed [SC_W-1:0] sc_rd_r;
  logic        [WW-1:0]   w_rd_r;

  // control and datapath registers
  logic [3:0]             st_r, st_nxt;
  logic [LC_W-1:0]        load_cnt_r, load_cnt_nxt;
  logic [ADDR_W-1:0]      fetch_r, fetch_nxt;
  logic [LC_W-1:0]        total_r, total_nxt;
  logic                   ready_r, ready_nxt;
  logic                   ovf_r, ovf_nxt;
  logic                   out_tvalid_r, out_tvalid_nxt;
  logic                   o_use_r, o_last_r;
  logic [1:0]             o_status_r;
  logic [LC_W-1:0]        rem_r, rem_nxt;
  logic [LC_W-1:0]        tot_r, tot_nxt;
  logic [SQ_W-1:0]        seq_r, seq_nxt;
  logic [SQ_W-1:0]        i_r, i_nxt;
  logic [SQ_W-1:0]        j_r, j_nxt;
  logic [HD_W-1:0]        k_r, k_nxt;
  logic [HD_W-1:0]        hw_r, hw_nxt;
  logic [LC_W-1:0]        bi_r, bi_nxt;
  logic [LC_W-1:0]        bj_r, bj_nxt;
  logic signed [DOT_W-1:0] dot_r, dot_nxt;
  logic signed [31:0]     pq_r, pq_nxt;
  logic signed [SP_W-1:0] sp_r, sp_nxt;
  logic signed [SC_W-1:0] mx_r, mx_nxt;
  logic [WS_W-1:0]        wsum_r, wsum_nxt;
  logic [IDX_W-1:0]       idx_r, idx_nxt;
  logic                   wz_r, wz_nxt;
  logic signed [PW_W-1:0] pw_r, pw_nxt;

  logic                   in_acc;
  logic                   out_load;
  logic                   o_use, o_last;
  logic [1:0]             o_status;
  logic                   ld_we, sc_we, w_we, res_we;
  logic [LC_W-1:0]        lc_inc;
  logic [LC_W-1:0]        aq, ak;
  logic [LC_W-1:0]        ares;
  logic signed [SP_W:0]   spx, spm;
  logic        [SP_W:0]   rnd;
  logic signed [SC_W-1:0] sc;
  logic signed [SC_W:0]   dd;
  logic [IP_W-1:0]        idx_prod;
  logic [WW-1:0]          wv;
  logic [HD_W-1:0]        hw_clamp;

  sdpa_pkg::cell_ctl_t    cell_ctl;
  logic [ACC_W-1:0]       cell_acc [MAX_HEAD_DIM];
  logic [ACC_W-1:0]       cell_tail;

  logic                   div_start, div_busy, div_done;
  logic [15:0]            div_quo;

  assign in_tready = (st_r == ST_IDLE) && (!out_tvalid_r || out_tready);
  assign in_acc    = in_tvalid && in_tready;
  assign aq        = bi_r + LC_W'(k_r);
  assign ak        = bj_r + LC_W'(k_r);
  assign ares      = aq;

  always_comb begin
    if (head_width_r == 7'd0) begin
      hw_clamp = HD_W'(1);
    end else if (int'(head_width_r) > MAX_HEAD_DIM) begin
      hw_clamp = HD_W'(MAX_HEAD_DIM);
    end else begin
      hw_clamp = HD_W'(head_width_r);
    end
  end

  // score rounding and table index
  always_comb begin
    spx = {sp_r[SP_W-1], sp_r};
    spm = spx[SP_W] ? -spx : spx;
    rnd = (SP_W + 1)'(($unsigned(spm) + (SP_W + 1)'(1 << 14)) >> 15);
    sc  = spx[SP_W] ? SC_W'(-rnd) : SC_W'(rnd);
    dd  = {mx_r[SC_W-1], mx_r} - {sc_rd_r[SC_W-1], sc_rd_r};
    idx_prod = IP_W'(dd[19:0]) * IP_W'(EXP_TABLE_DEPTH);
    wv = wz_r ? '0 : exp_tab[idx_r];
  end

  always_comb begin
    st_nxt         = st_r;
    load_cnt_nxt   = load_cnt_r;
    fetch_nxt      = fetch_r;
    total_nxt      = total_r;
    ready_nxt      = ready_r;
    ovf_nxt        = ovf_r;
    out_tvalid_nxt = out_tvalid_r;
    rem_nxt        = rem_r;
    tot_nxt        = tot_r;
    seq_nxt        = seq_r;
    i_nxt          = i_r;
    j_nxt          = j_r;
    k_nxt          = k_r;
    hw_nxt         = hw_r;
    bi_nxt         = bi_r;
    bj_nxt         = bj_r;
    dot_nxt        = dot_r;
    pq_nxt         = q_rd_r * k_rd_r;
    sp_nxt         = dot_r * $signed({1'b0, scale_r});
    mx_nxt         = mx_r;
    wsum_nxt       = wsum_r;
    idx_nxt        = idx_prod[20 +: IDX_W];
    wz_nxt         = |dd[SC_W:20];
    pw_nxt         = $signed({1'b0, w_rd_r}) * v_rd_r;
    out_load       = 1'b0;
    o_use          = 1'b0;
    o_last         = 1'b0;
    o_status       = sdpa_pkg::STATUS_EMPTY;
    ld_we          = 1'b0;
    sc_we          = 1'b0;
    w_we           = 1'b0;
    res_we         = 1'b0;
    lc_inc         = load_cnt_r;
    cell_ctl       = '0;
    cell_tail      = cell_acc[0];
    div_start      = 1'b0;

    if (out_tvalid_r && out_tready) begin
      out_tvalid_nxt = 1'b0;
    end

    unique case (st_r)
      ST_IDLE: begin
        if (in_acc && in_tuser[0] == sdpa_pkg::REQ_LOAD) begin
          if (load_cnt_r == '0) begin
            ready_nxt = 1'b0;
            fetch_nxt = '0;
            ovf_nxt   = 1'b0;
          end
          if (load_cnt_r < LC_W'(STORE_DEPTH)) begin
            ld_we  = 1'b1;
            lc_inc = load_cnt_r + LC_W'(1);
          end else begin
            ovf_nxt = 1'b1;
          end
          load_cnt_nxt = lc_inc;
          if (in_tlast) begin
            load_cnt_nxt = '0;
            rem_nxt      = lc_inc;
            tot_nxt      = '0;
            seq_nxt      = '0;
            hw_nxt       = hw_clamp;
            st_nxt       = ST_SEQ;
          end
        end else if (in_acc) begin
          out_load       = 1'b1;
          out_tvalid_nxt = 1'b1;
          if (ready_r && (LC_W'(fetch_r) < total_r)) begin
            o_use    = 1'b1;
            o_status = ovf_r ? sdpa_pkg::STATUS_OVERFLOW : sdpa_pkg::STATUS_VALID;
            if (LC_W'(fetch_r) + LC_W'(1) == total_r) begin
              o_last    = 1'b1;
              ready_nxt = 1'b0;
              fetch_nxt = '0;
            end else begin
              fetch_nxt = fetch_r + ADDR_W'(1);
            end
          end
        end
      end
      ST_SEQ: begin
        if (rem_r >= LC_W'(hw_r) && seq_r < SQ_W'(MAX_SEQ_LEN)) begin
          rem_nxt = rem_r - LC_W'(hw_r);
          tot_nxt = tot_r + LC_W'(hw_r);
          seq_nxt = seq_r + SQ_W'(1);
        end else if (seq_r == '0) begin
          ready_nxt = 1'b0;
          fetch_nxt = '0;
          total_nxt = '0;
          st_nxt    = ST_IDLE;
        end else begin
          i_nxt  = '0;
          bi_nxt = '0;
          st_nxt = ST_ROW;
        end
      end
      ST_ROW: begin
        cell_ctl.clear = 1'b1;
        wsum_nxt = '0;
        j_nxt    = '0;
        bj_nxt   = '0;
        k_nxt    = '0;
        dot_nxt  = '0;
        st_nxt   = ST_DRD;
      end
      ST_DRD:  st_nxt = ST_DMUL;
      ST_DMUL: st_nxt = ST_DACC;
      ST_DACC: begin
        dot_nxt = dot_r + DOT_W'(pq_r);
        k_nxt   = k_r + HD_W'(1);
        st_nxt  = (k_r + HD_W'(1) == hw_r) ? ST_SCL : ST_DRD;
      end
      ST_SCL:  st_nxt = ST_SRND;
      ST_SRND: begin
        sc_we   = 1'b1;
        if (j_r == '0 || sc > mx_r) begin
          mx_nxt = sc;
        end
        k_nxt   = '0;
        dot_nxt = '0;
        bj_nxt  = bj_r + LC_W'(hw_r);
        j_nxt   = j_r + SQ_W'(1);
        st_nxt  = ST_DRD;
        if (j_r + SQ_W'(1) == seq_r) begin
          j_nxt  = '0;
          st_nxt = ST_WRD;
        end
      end
      ST_WRD:  st_nxt = ST_WIDX;
      ST_WIDX: st_nxt = ST_WTAB;
      ST_WTAB: begin
        w_we     = 1'b1;
        wsum_nxt = wsum_r + WS_W'(wv);
        j_nxt    = j_r + SQ_W'(1);
        st_nxt   = ST_WRD;
        if (j_r + SQ_W'(1) == seq_r) begin
          j_nxt  = '0;
          k_nxt  = '0;
          bj_nxt = '0;
          st_nxt = ST_CRD;
        end
      end
      ST_CRD:  st_nxt = ST_CMUL;
      ST_CMUL: st_nxt = ST_CACC;
      ST_CACC: begin
        cell_ctl.shift = 1'b1;
        cell_tail = cell_acc[0] + ACC_W'(pw_r);
        k_nxt  = k_r + HD_W'(1);
        st_nxt = ST_CRD;
        if (k_r + HD_W'(1) == hw_r) begin
          k_nxt  = '0;
          j_nxt  = j_r + SQ_W'(1);
          bj_nxt = bj_r + LC_W'(hw_r);
          if (j_r + SQ_W'(1) == seq_r) begin
            st_nxt = ST_DIVS;
          end
        end
      end
      ST_DIVS: begin
        div_start = 1'b1;
        st_nxt    = ST_DIVW;
      end
      ST_DIVW: begin
        if (div_done) begin
          res_we = 1'b1;
          cell_ctl.shift = 1'b1;
          k_nxt  = k_r + HD_W'(1);
          st_nxt = ST_DIVS;
          if (k_r + HD_W'(1) == hw_r) begin
            i_nxt  = i_r + SQ_W'(1);
            bi_nxt = bi_r + LC_W'(hw_r);
            st_nxt = ST_ROW;
            if (i_r + SQ_W'(1) == seq_r) begin
              ready_nxt = 1'b1;
              fetch_nxt = '0;
              total_nxt = tot_r;
              st_nxt    = ST_IDLE;
            end
          end
        end
      end
      default: st_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r         <= ST_IDLE;
      load_cnt_r   <= '0;
      fetch_r      <= '0;
      total_r      <= '0;
      ready_r      <= 1'b0;
      ovf_r        <= 1'b0;
      out_tvalid_r <= 1'b0;
    end else begin
      st_r         <= st_nxt;
      load_cnt_r   <= load_cnt_nxt;
      fetch_r      <= fetch_nxt;
      total_r      <= total_nxt;
      ready_r      <= ready_nxt;
      ovf_r        <= ovf_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
    rem_r  <= rem_nxt;
    tot_r  <= tot_nxt;
    seq_r  <= seq_nxt;
    i_r    <= i_nxt;
    j_r    <= j_nxt;
    k_r    <= k_nxt;
    hw_r   <= hw_nxt;
    bi_r   <= bi_nxt;
    bj_r   <= bj_nxt;
    dot_r  <= dot_nxt;
    pq_r   <= pq_nxt;
    sp_r   <= sp_nxt;
    mx_r   <= mx_nxt;
    wsum_r <= wsum_nxt;
    idx_r  <= idx_nxt;
    wz_r   <= wz_nxt;
    pw_r   <= pw_nxt;
    if (out_load) begin
      o_use_r    <= o_use;
      o_last_r   <= o_last;
      o_status_r <= o_status;
    end
  end

  // memory ports
  always_ff @(posedge clk) begin
    if (ld_we) begin
      q_mem[load_cnt_r[ADDR_W-1:0]] <= in_tdata[15:0];
      k_mem[load_cnt_r[ADDR_W-1:0]] <= in_tdata[31:16];
      v_mem[load_cnt_r[ADDR_W-1:0]] <= in_tdata[47:32];
    end
    q_rd_r <= q_mem[aq[ADDR_W-1:0]];
    k_rd_r <= k_mem[ak[ADDR_W-1:0]];
    v_rd_r <= v_mem[ak[ADDR_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (sc_we) begin
      sc_mem[j_r[SI_W-1:0]] <= sc;
    end
    sc_rd_r <= sc_mem[j_r[SI_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (w_we) begin
      w_mem[j_r[SI_W-1:0]] <= wv;
    end
    w_rd_r <= w_mem[j_r[SI_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (res_we) begin
      res_mem[ares[ADDR_W-1:0]] <= div_quo;
    end
    if (out_load) begin
      res_rd_r <= res_mem[fetch_r];
    end
  end

  // accumulator chain
  for (genvar n = 0; n < MAX_HEAD_DIM; n++) begin : g_cell
    logic [ACC_W-1:0] nb;
    if (n == MAX_HEAD_DIM - 1) begin : g_end
      assign nb = '0;
    end else begin : g_mid
      assign nb = cell_acc[n+1];
    end
    sdpa_cell #(.W(ACC_W)) u_cell (
      .clk     (clk),
      .ctl     (cell_ctl),
      .is_tail (HD_W'(n) == hw_r - HD_W'(1)),
      .tail_in (cell_tail),
      .nb_in   (nb),
      .acc     (cell_acc[n])
    );
  end

  sdpa_div #(.NUM_W(ACC_W), .DEN_W(WS_W)) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   ($signed(cell_acc[0])),
    .den   (wsum_r),
    .busy  (div_busy),
    .done  (div_done),
    .quo   (div_quo)
  );

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = o_use_r ? res_rd_r : 16'd0;
  assign out_tlast  = o_last_r;
  assign out_tuser  = o_status_r;

`ifndef SYNTH
  a_fetch_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    ready_r |-> (LC_W'(fetch_r) < total_r))
    else $error("fetch position past result total");

  a_last_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_tuser[0] == sdpa_pkg::REQ_LOAD && in_tlast) |=> (st_r == ST_SEQ))
    else $error("last load did not start computation");

  a_div_free: assert property (@(posedge clk) disable iff (!rst_n)
    div_start |-> !div_busy)
    else $error("divider started while busy");

  a_total_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    ready_r |-> (total_r != '0))
    else $error("result ready with empty matrix");
`endif

endmodule
`default_nettype wire
